FILE: sv/stereo_feedback_delay_macros.svh
// Assertion macros shared by the stereo feedback delay RTL.
// Include by bare file name; every macro samples clk_i and is disabled while rst_ni is low.
`ifndef STEREO_FEEDBACK_DELAY_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_MACROS_SVH

// Plain property, checked at every rising clk_i edge out of reset.
`define SFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent this cycle, consequent from the next cycle on.
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  `SFD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: sv/sfd_pkg.sv
// Shared types and constants of the stereo feedback delay.
// No dependencies; imported by sfd_lane, stereo_feedback_delay and the testbench.
package sfd_pkg;

  // Default sizes handed down as top-level parameter defaults
  localparam int RING_DEPTH_DEF  = 131072;
  localparam int SAMPLE_BITS_DEF = 24;

  // Register widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TIME_W     = 11;
  localparam int RATE_W     = 16;
  localparam int FB_W       = 15;
  localparam int MIX_W      = 16;
  localparam int DRY_W      = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_MS = 2'd0,
    REG_RATE_HZ  = 2'd1,
    REG_FEEDBACK = 2'd2,
    REG_WET_MIX  = 2'd3
  } cfg_reg_e;

  // Limits and reset values
  localparam logic [TIME_W-1:0] TIME_MS_MIN = 11'd1;
  localparam logic [TIME_W-1:0] TIME_MS_MAX = 11'd2000;
  localparam logic [TIME_W-1:0] TIME_MS_RST = 11'd300;
  localparam logic [RATE_W-1:0] RATE_HZ_RST = 16'd48000;
  localparam logic [FB_W-1:0]   FB_MAX      = 15'd31130;
  localparam logic [FB_W-1:0]   FB_RST      = 15'd13107;
  localparam logic [MIX_W-1:0]  WET_MAX     = 16'd32768;
  localparam logic [MIX_W-1:0]  WET_RST     = 16'd11469;
  localparam logic [DRY_W-1:0]  Q15_ONE     = 17'd32768;
  localparam int                Q15_SHIFT   = 15;

  // Delay in samples: floor(ms * hz / 1000). The product is shifted down by 3,
  // then floor(y / 125) = (y * ceil(2^38 / 125)) >> 38, exact for y < 2^24.
  localparam int PROD_W          = TIME_W + RATE_W;
  localparam int RECIP_PRE_SHIFT = 3;
  localparam int RECIP_W         = 32;
  localparam logic [RECIP_W-1:0] RECIP_125 = 32'd2199023256;
  localparam int RECIP_SHIFT     = 38;
  localparam int RECIP_PROD_W    = PROD_W - RECIP_PRE_SHIFT + RECIP_W;
  localparam int QUOT_W          = RECIP_PROD_W - RECIP_SHIFT;

  // Clocks the delay pipeline needs after a register write or reset
  localparam int CFG_SETTLE = 3;
  localparam int HOLD_W     = $clog2(CFG_SETTLE + 1);

  // Output buffer; a power of two so the pointers wrap on their own
  localparam int OUT_FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W     = $clog2(OUT_FIFO_DEPTH);

  typedef struct packed {
    logic [FB_W-1:0]  feedback_gain;
    logic [MIX_W-1:0] wet_mix;
    logic [DRY_W-1:0] dry_mix;
  } gain_cfg_t;

  // fill_ok goes with the ring read, wr_en with the write-back two stages later
  typedef struct packed {
    logic fill_ok;
    logic wr_en;
  } lane_ctl_t;

endpackage

FILE: sv/sfd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Reads return the old contents when the same entry is written in that cycle. No dependencies.
module sfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/sfd_lane.sv
// One channel of the echo: ring RAM, feedback and wet/dry Q15 products, saturation.
// Depends on sfd_pkg and sfd_ram; control and addresses come from the top level.
module sfd_lane #(
  parameter int RING_DEPTH  = sfd_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF,
  localparam int ADDR_W = $clog2(RING_DEPTH)
) (
  input  logic                     clk_i,
  input  sfd_pkg::gain_cfg_t       gains_i,
  input  sfd_pkg::lane_ctl_t       ctl_i,
  input  logic [ADDR_W-1:0]        rd_addr_i,
  input  logic [ADDR_W-1:0]        wr_addr_i,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  output logic [SAMPLE_BITS-1:0]   sample_o
);

  import sfd_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int SW     = SB + 3;
  localparam int FBP_W  = SB + FB_W + 1;
  localparam int MIXP_W = SB + DRY_W + 1;
  localparam int ACC_W  = MIXP_W + 1;
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic signed [SB-1:0] sat(input logic signed [SW-1:0] x);
    logic signed [SB-1:0] r;
    if (x > SAT_HI) begin
      r = SAT_HI[SB-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[SB-1:0];
    end else begin
      r = x[SB-1:0];
    end
    return r;
  endfunction

  logic [SB-1:0]            rd_data;
  logic signed [SB-1:0]     in1_q, in2_q;
  logic                     fill_ok1_q;
  logic signed [SB-1:0]     wet;
  logic signed [FBP_W-1:0]  fbp_q;
  logic signed [MIXP_W-1:0] dryp_q, wetp_q;
  logic signed [ACC_W-1:0]  mix_acc;
  logic signed [SW-1:0]     fb_sum, mix_sum;
  logic signed [SB-1:0]     fb_val;

  sfd_ram #(
    .WIDTH(SB),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ctl_i.wr_en),
    .waddr_i(wr_addr_i),
    .wdata_i(fb_val),
    .raddr_i(rd_addr_i),
    .rdata_o(rd_data)
  );

  // Entries never written since reset read as zero
  assign wet = fill_ok1_q ? $signed(rd_data) : '0;

  always_ff @(posedge clk_i) begin
    in1_q      <= $signed(sample_i);
    fill_ok1_q <= ctl_i.fill_ok;
    in2_q      <= in1_q;
    fbp_q      <= wet * $signed({1'b0, gains_i.feedback_gain});
    dryp_q     <= in1_q * $signed({1'b0, gains_i.dry_mix});
    wetp_q     <= wet * $signed({1'b0, gains_i.wet_mix});
  end

  // Arithmetic shifts give floor rounding
  assign fb_sum  = SW'(in2_q) + SW'(fbp_q >>> Q15_SHIFT);
  assign fb_val  = sat(fb_sum);
  assign mix_acc = ACC_W'(dryp_q) + ACC_W'(wetp_q);
  assign mix_sum = SW'(mix_acc >>> Q15_SHIFT);
  assign sample_o = sat(mix_sum);

endmodule

FILE: sv/stereo_feedback_delay.sv
// Stereo feedback delay: one beat carries a left and a right sample; each channel
// reads a delayed sample from its ring RAM, writes back input plus feedback and
// outputs a Q15 wet/dry mix. The ring write pointer and read address are computed
// here; the per-channel datapath lives in sfd_lane. A frame is taken per clock
// unless input is held off; samples and ring read are registered, then the products,
// and the saturated mix enters the output buffer. With a delay of one or two samples
// the next frame waits until the previous ring write-back is done. After reset and
// after every register write the input holds off while the delay in samples is
// recomputed (ms times Hz, reciprocal multiply for the division by 1000, clamp). A
// four-beat output buffer takes up stalls on m_axis. Ring entries not yet written
// since reset read as zero by a fill mark on the write pointer, so no clearing pass
// runs. Depends on sfd_pkg, sfd_lane, sfd_ram and stereo_feedback_delay_macros.svh.
`include "stereo_feedback_delay_macros.svh"

module stereo_feedback_delay #(
  parameter int RING_DEPTH  = sfd_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF,
  localparam int DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Stereo input: tdata = left_in, right_in (from bit 0 up), zero pad
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [DATA_W-1:0]             s_axis_tdata,
  // Stereo output: tdata = left_out, right_out (from bit 0 up), zero pad
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [DATA_W-1:0]             m_axis_tdata,
  // Register writes
  input  logic                          cfg_we_i,
  input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import sfd_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int ADDR_W = $clog2(RING_DEPTH);
  localparam int CW     = ((ADDR_W > QUOT_W) ? ADDR_W : QUOT_W) + 1;
  localparam int OCC_W  = FIFO_PTR_W + 2;
  localparam logic [ADDR_W-1:0] LAST_POS  = ADDR_W'(RING_DEPTH - 1);
  localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W + 1)'(RING_DEPTH);

  // ---------------- configuration ----------------
  logic [TIME_W-1:0] time_q, time_wr;
  logic [RATE_W-1:0] rate_q;
  gain_cfg_t         gains_q;
  logic [FB_W-1:0]   fb_wr;
  logic [MIX_W-1:0]  mix_wr;
  logic [HOLD_W-1:0] hold_q;

  always_comb begin
    time_wr = cfg_data_i[TIME_W-1:0];
    if (time_wr < TIME_MS_MIN) begin
      time_wr = TIME_MS_MIN;
    end else if (time_wr > TIME_MS_MAX) begin
      time_wr = TIME_MS_MAX;
    end
    fb_wr  = (cfg_data_i[FB_W-1:0] > FB_MAX) ? FB_MAX : cfg_data_i[FB_W-1:0];
    mix_wr = (cfg_data_i[MIX_W-1:0] > WET_MAX) ? WET_MAX : cfg_data_i[MIX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q                <= TIME_MS_RST;
      rate_q                <= RATE_HZ_RST;
      gains_q.feedback_gain <= FB_RST;
      gains_q.wet_mix       <= WET_RST;
      gains_q.dry_mix       <= Q15_ONE - DRY_W'(WET_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DELAY_MS: time_q <= time_wr;
        REG_RATE_HZ:  rate_q <= cfg_data_i[RATE_W-1:0];
        REG_FEEDBACK: gains_q.feedback_gain <= fb_wr;
        REG_WET_MIX: begin
          gains_q.wet_mix <= mix_wr;
          gains_q.dry_mix <= Q15_ONE - DRY_W'(mix_wr);
        end
        default: ;
      endcase
    end
  end

  // Hold off input until the delay pipeline has settled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HOLD_W'(CFG_SETTLE);
    end else if (cfg_we_i) begin
      hold_q <= HOLD_W'(CFG_SETTLE);
    end else if (hold_q != '0) begin
      hold_q <= hold_q - 1'b1;
    end
  end

  // ---------------- delay in samples ----------------
  logic [PROD_W-1:0]       prod_q;
  logic [RECIP_PROD_W-1:0] recip_q;
  logic [QUOT_W-1:0]       quot;
  logic [CW-1:0]           quot_ext;
  logic [ADDR_W-1:0]       d_q, d_d;

  assign quot     = recip_q[RECIP_SHIFT +: QUOT_W];
  assign quot_ext = CW'(quot);

  always_comb begin
    if (quot == '0) begin
      d_d = ADDR_W'(1);
    end else if (quot_ext > CW'(LAST_POS)) begin
      d_d = LAST_POS;
    end else begin
      d_d = quot_ext[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= time_q * rate_q;
    recip_q <= prod_q[PROD_W-1:RECIP_PRE_SHIFT] * RECIP_125;
    d_q     <= d_d;
  end

  // ---------------- ring addressing and pipeline control ----------------
  logic              in_fire;
  logic [ADDR_W-1:0] wp_q, rpos;
  logic [ADDR_W:0]   rpos_wrap;
  logic              wrapped_q;
  logic              hazard;
  logic              s1_v_q, s2_v_q;
  logic [ADDR_W-1:0] s1_wp_q, s2_wp_q;
  logic [OCC_W-1:0]  occ;
  logic [FIFO_PTR_W:0] cnt_q;
  lane_ctl_t         ctl;

  assign rpos_wrap = {1'b0, wp_q} + DEPTH_EXT - {1'b0, d_q};
  assign rpos      = (wp_q >= d_q) ? (wp_q - d_q) : rpos_wrap[ADDR_W-1:0];

  // A frame must not read an entry whose write-back is still in flight
  assign hazard = (s1_v_q && (s1_wp_q == rpos)) || (s2_v_q && (s2_wp_q == rpos));
  assign occ    = OCC_W'(cnt_q) + OCC_W'(s1_v_q) + OCC_W'(s2_v_q);

  assign s_axis_tready = (hold_q == '0) && !hazard && (occ < OCC_W'(OUT_FIFO_DEPTH));
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign ctl.fill_ok = wrapped_q || (rpos < wp_q);
  assign ctl.wr_en   = s2_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
    end else begin
      s1_v_q <= in_fire;
      s2_v_q <= s1_v_q;
      if (in_fire) begin
        if (wp_q == LAST_POS) begin
          wp_q      <= '0;
          wrapped_q <= 1'b1;
        end else begin
          wp_q <= wp_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_wp_q <= wp_q;
    s2_wp_q <= s1_wp_q;
  end

  // ---------------- channel datapaths ----------------
  logic [SB-1:0] left_out, right_out;

  sfd_lane #(
    .RING_DEPTH (RING_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_left (
    .clk_i    (clk_i),
    .gains_i  (gains_q),
    .ctl_i    (ctl),
    .rd_addr_i(rpos),
    .wr_addr_i(s2_wp_q),
    .sample_i (s_axis_tdata[SB-1:0]),
    .sample_o (left_out)
  );

  sfd_lane #(
    .RING_DEPTH (RING_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_right (
    .clk_i    (clk_i),
    .gains_i  (gains_q),
    .ctl_i    (ctl),
    .rd_addr_i(rpos),
    .wr_addr_i(s2_wp_q),
    .sample_i (s_axis_tdata[2*SB-1:SB]),
    .sample_o (right_out)
  );

  // ---------------- output buffer ----------------
  logic [2*SB-1:0]       fifo_q [OUT_FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic                  fifo_push, fifo_pop;

  assign fifo_push = s2_v_q;
  assign fifo_pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (fifo_push) begin
      fifo_q[wr_ptr_q] <= {right_out, left_out};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (fifo_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (fifo_push && !fifo_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (fifo_pop && !fifo_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = DATA_W'(fifo_q[rd_ptr_q]);

  // ---------------- assertions ----------------
  `SFD_ASSERT_NEXT(a_cfg_settle, cfg_we_i, !in_fire ##1 !in_fire ##1 !in_fire,
                   "frame taken before delay recomputed")
  `SFD_ASSERT(a_result_follows, in_fire |-> ##2 fifo_push, "accepted frame lost in pipeline")
  `SFD_ASSERT(a_no_overflow, occ <= OCC_W'(OUT_FIFO_DEPTH), "output buffer overcommitted")
  `SFD_ASSERT(a_delay_range, (hold_q == '0) |-> ((d_q != '0) && (d_q <= LAST_POS)),
              "delay out of range")
  `SFD_ASSERT(a_wrap_sticky, !$fell(wrapped_q), "ring fill mark cleared")

endmodule

FILE: verif/tb_stereo_feedback_delay.sv
// Self-checking testbench for stereo_feedback_delay: drives stereo beats and register
// writes, predicts every mixed output frame from its own ring and register copies.
// Depends on sfd_pkg and the stereo_feedback_delay RTL.
module tb_stereo_feedback_delay;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  localparam int SW         = SAMPLE_BITS_DEF;
  localparam int DEPTH      = RING_DEPTH_DEF;
  localparam int DATA_W     = ((2 * SW + 7) / 8) * 8;
  localparam int IDLE_PCT   = 31;
  localparam int TAIL       = 16;
  localparam int STALL_MAX  = 4000;
  localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic signed [SW-1:0] right;
    logic signed [SW-1:0] left;
  } stereo_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [DATA_W-1:0]     s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DATA_W-1:0]     m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  stereo_feedback_delay dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Echo state as the block should hold it
  bit signed [SW-1:0] echo_ring [2][DEPTH];
  int unsigned        ring_wr_pos = 0;
  logic [TIME_W-1:0]  time_ms = TIME_MS_RST;
  logic [RATE_W-1:0]  rate_hz = RATE_HZ_RST;
  logic [FB_W-1:0]    feedback = FB_RST;
  logic [MIX_W-1:0]   wet_share = WET_RST;

  stereo_t mix_due [$];
  int      mismatches = 0;
  bit      calm = 1'b0;
  int      rx_hold_left = 0;
  int      quiet_cycles = 0;

  function automatic logic signed [SW-1:0] clip(input longint x);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SW - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi[SW-1:0];
    if (x < lo) return lo[SW-1:0];
    return x[SW-1:0];
  endfunction

  // Read the delayed sample, write back input plus feedback, push the wet/dry mix
  task automatic predict_mix(input stereo_t f);
    longint      span;
    longint      dry [2];
    longint      wet;
    int unsigned rd;
    stereo_t     res;
    logic signed [SW-1:0] mixed [2];
    span = (longint'(time_ms) * longint'(rate_hz)) / 1000;
    if (span < 1) span = 1;
    if (span > DEPTH - 1) span = DEPTH - 1;
    rd = int'((longint'(ring_wr_pos) + DEPTH - span) % DEPTH);
    dry[0] = longint'(f.left);
    dry[1] = longint'(f.right);
    for (int ch = 0; ch < 2; ch++) begin
      wet = longint'(echo_ring[ch][rd]);
      echo_ring[ch][ring_wr_pos] =
          clip(dry[ch] + ((wet * longint'(feedback)) >>> Q15_SHIFT));
      mixed[ch] = clip((dry[ch] * (longint'(Q15_ONE) - longint'(wet_share))
                        + wet * longint'(wet_share)) >>> Q15_SHIFT);
    end
    res.left  = mixed[0];
    res.right = mixed[1];
    mix_due.push_back(res);
    ring_wr_pos = (ring_wr_pos + 1) % DEPTH;
  endtask

  // Offer one beat, idling first at random; valid stays high after acceptance
  task automatic send_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r);
    stereo_t f;
    f.left  = l;
    f.right = r;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'(f);
    do @(posedge clk_i); while (!s_axis_tready);
    predict_mix(f);
  endtask

  // Drop valid and wait until every expected frame has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (mix_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    logic [TIME_W-1:0] t;
    logic [FB_W-1:0]   g;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_DELAY_MS: begin
        t = data[TIME_W-1:0];
        if (t < TIME_MS_MIN) t = TIME_MS_MIN;
        if (t > TIME_MS_MAX) t = TIME_MS_MAX;
        time_ms = t;
      end
      REG_RATE_HZ: rate_hz = data[RATE_W-1:0];
      REG_FEEDBACK: begin
        g = data[FB_W-1:0];
        feedback = (g > FB_MAX) ? FB_MAX : g;
      end
      REG_WET_MIX: wet_share = (data[MIX_W-1:0] > WET_MAX) ? WET_MAX : data[MIX_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic signed [SW-1:0] random_sample();
    int v;
    v = int'($urandom_range(0, 8191)) - 4096;
    case ($urandom_range(9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2, 3:    return v[SW-1:0];
      default: return SW'($urandom);
    endcase
  endfunction

  // Only short delays so the echo comes back within a phase
  task automatic pick_settings();
    case ($urandom_range(3))
      0: begin
        write_reg(REG_DELAY_MS, CFG_DATA_W'($urandom_range(1, 3)));
        write_reg(REG_RATE_HZ, CFG_DATA_W'($urandom_range(8000, 48000)));
      end
      1: begin
        write_reg(REG_DELAY_MS, CFG_DATA_W'($urandom_range(0, 2)));
        write_reg(REG_RATE_HZ, CFG_DATA_W'($urandom_range(0, 65535)));
      end
      2: begin
        write_reg(REG_DELAY_MS, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(REG_RATE_HZ, CFG_DATA_W'($urandom_range(0, 40)));
      end
      default: begin
        write_reg(REG_DELAY_MS, CFG_DATA_W'($urandom_range(4, 10)));
        write_reg(REG_RATE_HZ, CFG_DATA_W'($urandom_range(0, 16000)));
      end
    endcase
    if ($urandom_range(1) == 0) write_reg(REG_FEEDBACK, CFG_DATA_W'($urandom_range(0, 65535)));
    else write_reg(REG_FEEDBACK, CFG_DATA_W'($urandom_range(0, 31130)));
    case ($urandom_range(3))
      0:       write_reg(REG_WET_MIX, CFG_DATA_W'($urandom_range(0, 65535)));
      1:       write_reg(REG_WET_MIX, CFG_DATA_W'($urandom_range(0, 32768)));
      2:       write_reg(REG_WET_MIX, '0);
      default: write_reg(REG_WET_MIX, 16'd32768);
    endcase
  endtask

  task automatic test_reset_settings();
    send_frame(SMP_MAX, SMP_MIN);
    send_frame(SMP_MIN, SMP_MAX);
    send_frame('0, '1);
    send_frame('1, '0);
    send_frame(24'h555555, 24'hAAAAAA);
    send_frame(24'hAAAAAA, 24'h555555);
  endtask

  task automatic test_short_delays();
    drain();
    // delay 0 clamps to 1 ms, 1 kHz gives one sample; oversize gains clamp
    write_reg(REG_DELAY_MS, '0);
    write_reg(REG_RATE_HZ, 16'd1000);
    write_reg(REG_FEEDBACK, 16'hFFFF);
    write_reg(REG_WET_MIX, 16'hFFFF);
    repeat (3) send_frame(SMP_MAX, SMP_MIN);
    send_frame(SMP_MIN, SMP_MAX);
    send_frame(SMP_MIN, SMP_MAX);
    drain();
    write_reg(REG_RATE_HZ, '0);
    write_reg(REG_WET_MIX, '0);
    send_frame(SMP_MAX, 24'd12345);
    send_frame(SMP_MIN, -24'sd12345);
    drain();
    write_reg(REG_RATE_HZ, 16'd2000);
    write_reg(REG_WET_MIX, 16'd16384);
    send_frame(SMP_MAX, SMP_MAX);
    send_frame(SMP_MIN, SMP_MIN);
    send_frame(24'd1, -24'sd1);
  endtask

  task automatic test_longest_delay();
    drain();
    write_reg(REG_DELAY_MS, 16'hFFFF);
    write_reg(REG_RATE_HZ, 16'hFFFF);
    write_reg(REG_FEEDBACK, 16'h8000);
    write_reg(REG_WET_MIX, 16'd32768);
    repeat (3) send_frame(random_sample(), random_sample());
  endtask

  task automatic test_output_stall();
    drain();
    pick_settings();
    rx_hold_left = 300;
    repeat (60) send_frame(random_sample(), random_sample());
  endtask

  task automatic test_sender_pause();
    drain();
    pick_settings();
    repeat (30) send_frame(random_sample(), random_sample());
    drain();
    repeat (30) send_frame(random_sample(), random_sample());
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      pick_settings();
      calm = (ph == 5);
      repeat (200) send_frame(random_sample(), random_sample());
    end
    calm = 1'b0;
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic report_field(input string name, input logic signed [SW-1:0] want,
                              input logic signed [SW-1:0] got);
    if (mismatches < 10)
      $display("mismatch %s: expected %0d, got %0d", name, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    stereo_t got;
    stereo_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[2*SW-1:0];
      if (mix_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected frame: left %0d, right %0d", got.left, got.right);
        mismatches++;
      end else begin
        want = mix_due.pop_front();
        if (got.left !== want.left) report_field("left", want.left, got.left);
        if (got.right !== want.right) report_field("right", want.right, got.right);
      end
    end
  end

  // Abort when neither side has moved a beat for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_settings();
    test_short_delays();
    test_longest_delay();
    test_output_stall();
    test_sender_pause();
    test_random_phases();
    drain();
    repeat (TAIL) @(posedge clk_i);
    if (mismatches == 0 && mix_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
